@@ rtl/tccw_pkg.sv @@
// Shared types and constants for the text console character writer.
// Used by the channel interfaces, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int TAB_STOP_DEF    = 8;

  localparam int COL_COUNT_RESET = 80;
  localparam int ROW_COUNT_RESET = 25;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ROW_CFG_W  = 7;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd1;

  localparam logic [CHAR_W-1:0] CH_BEL     = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  typedef struct packed {
    logic [COLUMN_W-1:0] cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic                unhandled_control;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/tccw_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
// Depends on tccw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tccw_in_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAR_W-1:0]   char_code;
  logic [ATTR_W-1:0]   char_attr;
  logic [COLUMN_W-1:0] read_column;
  logic [ROW_W-1:0]    read_row;

  modport source (output valid, op, char_code, char_attr, read_column, read_row,
                  input ready);
  modport sink (input valid, op, char_code, char_attr, read_column, read_row,
                output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] cursor_column;
  logic [ROW_W-1:0]    cursor_row;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;
  logic                unhandled_control;

  modport source (output valid, cursor_column, cursor_row, cell_char, cell_attr,
                  unhandled_control, input ready);
  modport sink (input valid, cursor_column, cursor_row, cell_char, cell_attr,
                unhandled_control, output ready);
endinterface

`default_nettype wire

@@ rtl/text_console_character_writer_top.sv @@
// Top level of the text console character writer: cell memory, cursor and control.
// Depends on tccw_pkg, the channel interfaces and tccw_out_queue.
//
// Input beats arrive on in_ch and each one yields exactly one result beat on out_ch,
// in order. A put or any unused op code pushes its result into the result queue as
// it is accepted. A read loads the registered read port of the cell memory and its
// result is pushed from the read state, in which no new beat is taken. A clear
// pushes its result as it is accepted and then walks all MAX_COLUMNS * MAX_ROWS
// cells (8192 at the defaults), one cell per cycle, before the next beat is taken.
// Puts therefore run at one beat per cycle while the result queue has a free entry.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the column and row
// counts, which are clamped on entry. After reset the cursor is home, the counts
// are 80 and 25, and the same clearing walk over all MAX_COLUMNS * MAX_ROWS cells
// runs before in_ch.ready rises. Results sit in a two-entry queue, so input keeps
// flowing while out_ch is stalled until both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module text_console_character_writer_top #(
  parameter int MAX_COLUMNS = tccw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF,
  parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tccw_in_if.sink                             in_ch,
  tccw_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tccw_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CC_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int TW    = $clog2(MAX_COLUMNS + TAB_STOP);
  localparam int PH_W  = $clog2(TAB_STOP);
  localparam int WORD_W = CHAR_W + ATTR_W;
  localparam int COLS_RST = (COL_COUNT_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COL_COUNT_RESET;
  localparam int ROWS_RST = (ROW_COUNT_RESET > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RESET;

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   sweep_addr_r, sweep_addr_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [CC_W-1:0] eff_cols_r;
  logic [RC_W-1:0] eff_rows_r;
  logic            rd_in_range_r;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_q_r;

  logic              in_fire;
  logic              q_space;
  logic              push;
  res_t              push_data;
  res_t              head;
  logic              head_valid;
  logic              flag;
  logic              put_we;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              rd_in_range;
  logic [AW-1:0]     put_addr;
  logic [CC_W-1:0]   col_inc;
  logic [RC_W-1:0]   row_inc;
  logic [TW-1:0]     tab_col;
  logic [8:0]        cfg_cols_raw;
  logic [7:0]        cfg_rows_raw;
  logic [CC_W-1:0]   cfg_cols_eff;
  logic [RC_W-1:0]   cfg_rows_eff;
  logic [CW+COLUMN_W-1:0] col_ext;
  logic [RW+ROW_W-1:0]    row_ext;

  // Configuration registers hold the clamped counts.
  always_comb begin
    cfg_cols_raw = {1'b0, cfg_wdata};
    cfg_rows_raw = {1'b0, cfg_wdata[ROW_CFG_W-1:0]};
    if (cfg_cols_raw == 9'd0) begin
      cfg_cols_eff = CC_W'(1);
    end else if (cfg_cols_raw > 9'(MAX_COLUMNS)) begin
      cfg_cols_eff = CC_W'(MAX_COLUMNS);
    end else begin
      cfg_cols_eff = CC_W'(cfg_cols_raw);
    end
    if (cfg_rows_raw == 8'd0) begin
      cfg_rows_eff = RC_W'(1);
    end else if (cfg_rows_raw > 8'(MAX_ROWS)) begin
      cfg_rows_eff = RC_W'(MAX_ROWS);
    end else begin
      cfg_rows_eff = RC_W'(cfg_rows_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_cols_r <= CC_W'(COLS_RST);
      eff_rows_r <= RC_W'(ROWS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMN_COUNT: eff_cols_r <= cfg_cols_eff;
        CFG_ROW_COUNT:    eff_rows_r <= cfg_rows_eff;
        default: ;
      endcase
    end
  end

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_RUN) && q_space;

  always_comb begin
    col_inc  = CC_W'(cur_col_r) + CC_W'(1);
    row_inc  = RC_W'(cur_row_r) + RC_W'(1);
    if (phase_r == '0) begin
      tab_col = TW'(cur_col_r);
    end else begin
      tab_col = TW'(cur_col_r) + TW'(TAB_STOP) - TW'(phase_r);
    end
    put_addr    = AW'(AW'(cur_row_r) * AW'(MAX_COLUMNS) + AW'(cur_col_r));
    rd_addr     = AW'(AW'(in_ch.read_row) * AW'(MAX_COLUMNS) + AW'(in_ch.read_column));
    rd_in_range = ({2'b00, in_ch.read_column} < 9'(MAX_COLUMNS))
               && ({2'b00, in_ch.read_row} < 8'(MAX_ROWS));
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    phase_nxt      = phase_r;
    flag           = 1'b0;
    put_we         = 1'b0;
    rd_en          = 1'b0;
    unique case (state_r)
      S_RUN: begin
        if (in_fire) begin
          unique case (in_ch.op)
            OP_PUT: begin
              if (in_ch.char_code >= BLANK_CHAR) begin
                put_we = 1'b1;
                if (col_inc >= eff_cols_r) begin
                  cur_col_nxt = '0;
                  phase_nxt   = '0;
                  cur_row_nxt = (row_inc >= eff_rows_r) ? '0 : RW'(row_inc);
                end else begin
                  cur_col_nxt = CW'(col_inc);
                  phase_nxt   = (phase_r == PH_W'(TAB_STOP - 1)) ? '0 : phase_r + PH_W'(1);
                end
              end else begin
                unique case (in_ch.char_code)
                  CH_BS: begin
                    if (cur_col_r != '0) begin
                      cur_col_nxt = cur_col_r - CW'(1);
                      phase_nxt   = (phase_r == '0) ? PH_W'(TAB_STOP - 1)
                                                    : phase_r - PH_W'(1);
                    end
                  end
                  CH_TAB: begin
                    phase_nxt   = '0;
                    cur_col_nxt = (tab_col >= TW'(eff_cols_r)) ? '0 : CW'(tab_col);
                  end
                  CH_LF: begin
                    cur_col_nxt = '0;
                    phase_nxt   = '0;
                    if (row_inc < eff_rows_r) begin
                      cur_row_nxt = RW'(row_inc);
                    end
                  end
                  CH_CR: begin
                    cur_col_nxt = '0;
                    phase_nxt   = '0;
                  end
                  CH_BEL: ;
                  default: flag = 1'b1;
                endcase
              end
            end
            OP_READ: begin
              rd_en     = 1'b1;
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              cur_col_nxt    = '0;
              cur_row_nxt    = '0;
              phase_nxt      = '0;
              sweep_addr_nxt = '0;
              state_nxt      = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_RUN;
      end
      S_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_addr_r <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      phase_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      phase_r      <= phase_nxt;
    end
  end

  always_comb begin
    mem_we    = put_we || (state_r == S_SWEEP);
    mem_waddr = (state_r == S_SWEEP) ? sweep_addr_r : put_addr;
    mem_wdata = (state_r == S_SWEEP) ? {BLANK_CHAR, ATTR_W'(0)}
                                     : {in_ch.char_code, in_ch.char_attr};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r        <= mem_r[rd_addr];
      rd_in_range_r <= rd_in_range;
    end
  end

  always_comb begin
    col_ext = {{COLUMN_W{1'b0}}, cur_col_nxt};
    row_ext = {{ROW_W{1'b0}}, cur_row_nxt};
    push    = (in_fire && (in_ch.op != OP_READ)) || (state_r == S_READ);
    push_data.cursor_column     = col_ext[COLUMN_W-1:0];
    push_data.cursor_row        = row_ext[ROW_W-1:0];
    push_data.unhandled_control = flag;
    if ((state_r == S_READ) && rd_in_range_r) begin
      push_data.cell_char = rd_q_r[WORD_W-1:ATTR_W];
      push_data.cell_attr = rd_q_r[ATTR_W-1:0];
    end else begin
      push_data.cell_char = '0;
      push_data.cell_attr = '0;
    end
  end

  tccw_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop_ready  (out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .has_space  (q_space)
  );

  assign out_ch.valid             = head_valid;
  assign out_ch.cursor_column     = head.cursor_column;
  assign out_ch.cursor_row        = head.cursor_row;
  assign out_ch.cell_char         = head.cell_char;
  assign out_ch.cell_attr         = head.cell_attr;
  assign out_ch.unhandled_control = head.unhandled_control;

  // A read beat always produces its result in the following cycle.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.op == OP_READ)) |=> (push && (state_r == S_READ)))
    else $error("read result not produced one cycle after the read beat");

  // A clear starts the walk at the first cell with the cursor homed.
  a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.op == OP_CLEAR)) |=>
      ((state_r == S_SWEEP) && (sweep_addr_r == '0) && (cur_col_r == '0)
       && (cur_row_r == '0)))
    else $error("clear did not start the clearing walk");

  // The cursor never leaves the cell memory.
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_col_r} < (CW + 1)'(MAX_COLUMNS)) && ({1'b0, cur_row_r} < (RW + 1)'(MAX_ROWS)))
    else $error("cursor outside the cell memory");

  // The result queue is never pushed while it has no free entry.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_space) |-> out_ch.ready)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

@@ rtl/tccw_out_queue.sv @@
// Two-entry result queue that decouples the writer from a stalled receiver.
// Depends on tccw_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module tccw_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tccw_pkg::res_t push_data,
  input  wire logic          pop_ready,
  output tccw_pkg::res_t     head,
  output logic               head_valid,
  output logic               has_space
);
  import tccw_pkg::*;

  res_t       slot0_r;
  res_t       slot1_r;
  logic [1:0] occ_r;
  logic [1:0] occ_nxt;
  logic [1:0] occ_after_pop;
  logic       pop;

  assign head_valid = (occ_r != 2'd0);
  assign has_space  = (occ_r != 2'd2);
  assign head       = slot0_r;
  assign pop        = head_valid && pop_ready;

  always_comb begin
    occ_after_pop = occ_r - {1'b0, pop};
    occ_nxt       = occ_after_pop + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= slot1_r;
    end
    if (push) begin
      if (occ_after_pop == 2'd0) begin
        slot0_r <= push_data;
      end else begin
        slot1_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire
